### hw/rtl/binary_morphology_filter_top_defines.svh
// assertion macros shared by the checker of the morphology filter
// each macro expects clk and rst_n in the scope where it is used
`ifndef BINARY_MORPHOLOGY_FILTER_TOP_DEFINES_SVH
`define BINARY_MORPHOLOGY_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define BMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bmf_pkg.sv
// shared types, constants and helper functions of the morphology filter
// no dependencies
`default_nettype none

package bmf_pkg;

    localparam int WIN        = 15;
    localparam int HALF       = WIN / 2;
    localparam int TAPS       = WIN - 1;
    localparam int MASK_BITS  = WIN * WIN;
    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int PTR_W      = $clog2(MAX_W);
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 13;
    localparam int COL_W      = PTR_W + 2;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

    typedef enum logic [1:0] {
        MODE_ERODE,
        MODE_DILATE,
        MODE_OPEN,
        MODE_CLOSE
    } mode_t;

    typedef enum logic [2:0] {
        REG_OP_MODE,
        REG_MASK0,
        REG_MASK1,
        REG_MASK2,
        REG_MASK3,
        REG_WIDTH,
        REG_HEIGHT
    } reg_idx_t;

    typedef enum logic {
        CMD_PUSH,
        CMD_FLUSH
    } cmd_t;

    typedef logic signed [ROW_W-1:0] row_t;
    typedef logic [PTR_W-1:0]        col_t;
    typedef logic [DIM_W-1:0]        dim_t;

    typedef struct packed {
        mode_t                 mode;
        logic [MASK_BITS-1:0]  mask;
        dim_t                  width;
        dim_t                  height;
    } frame_cfg_t;

    typedef struct packed {
        row_t row;
        col_t col;
    } center_t;

    // per-tick side information traveling with the window stages
    typedef struct packed {
        center_t q1;
        center_t qo;
        logic    emit;
        logic    last;
        logic    s1_bit;
    } tick_t;

    function automatic dim_t clamp_dim(input dim_t v, input dim_t lim);
        dim_t r;
        if (v == '0)
            r = dim_t'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

    function automatic center_t advance(input center_t c, input dim_t w);
        center_t r;
        if ({1'b0, c.col} == w - dim_t'(1)) begin
            r.col = '0;
            r.row = c.row + row_t'(1);
        end
        else begin
            r.col = c.col + col_t'(1);
            r.row = c.row;
        end
        return r;
    endfunction

    // center of the window at the first tick of a frame: one lag (7w+7) or two
    function automatic center_t lag_start(input dim_t w, input logic two);
        center_t r;
        r.row = row_t'(-8);
        r.col = '0;
        if (!two) begin
            if (w >= dim_t'(8)) begin
                r.row = row_t'(-8);
                r.col = col_t'(w - dim_t'(7));
            end
            else begin
                unique case (w[2:0])
                    3'd2:    begin r.row = row_t'(-11); r.col = col_t'(1); end
                    3'd3:    begin r.row = row_t'(-10); r.col = col_t'(2); end
                    3'd4:    begin r.row = row_t'(-9);  r.col = col_t'(1); end
                    3'd5:    begin r.row = row_t'(-9);  r.col = col_t'(3); end
                    3'd6:    begin r.row = row_t'(-9);  r.col = col_t'(5); end
                    3'd7:    begin r.row = row_t'(-8);  r.col = col_t'(0); end
                    default: begin r.row = row_t'(-14); r.col = col_t'(0); end
                endcase
            end
        end
        else begin
            if (w >= dim_t'(15)) begin
                r.row = row_t'(-15);
                r.col = col_t'(w - dim_t'(14));
            end
            else begin
                unique case (w[3:0])
                    4'd2:    begin r.row = row_t'(-21); r.col = col_t'(0);  end
                    4'd3:    begin r.row = row_t'(-19); r.col = col_t'(1);  end
                    4'd4:    begin r.row = row_t'(-18); r.col = col_t'(2);  end
                    4'd5:    begin r.row = row_t'(-17); r.col = col_t'(1);  end
                    4'd6:    begin r.row = row_t'(-17); r.col = col_t'(4);  end
                    4'd7:    begin r.row = row_t'(-16); r.col = col_t'(0);  end
                    4'd8:    begin r.row = row_t'(-16); r.col = col_t'(2);  end
                    4'd9:    begin r.row = row_t'(-16); r.col = col_t'(4);  end
                    4'd10:   begin r.row = row_t'(-16); r.col = col_t'(6);  end
                    4'd11:   begin r.row = row_t'(-16); r.col = col_t'(8);  end
                    4'd12:   begin r.row = row_t'(-16); r.col = col_t'(10); end
                    4'd13:   begin r.row = row_t'(-16); r.col = col_t'(12); end
                    4'd14:   begin r.row = row_t'(-15); r.col = col_t'(0);  end
                    default: begin r.row = row_t'(-28); r.col = col_t'(0);  end
                endcase
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bmf_cfg_regs.sv
// configuration register file on the apb-style port
// depends on bmf_pkg
`default_nettype none

module bmf_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bmf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bmf_pkg::DATA_W-1:0]    pwdata,
    output logic      [bmf_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output bmf_pkg::frame_cfg_t                cfg
);

    bmf_pkg::mode_t                      mode_reg;
    logic [bmf_pkg::MASK_BITS-1:0]       mask_reg;
    bmf_pkg::dim_t                       width_reg;
    bmf_pkg::dim_t                       height_reg;
    bmf_pkg::reg_idx_t                   idx;
    logic                                wr_en;

    assign idx    = bmf_pkg::reg_idx_t'(paddr[bmf_pkg::ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bmf_pkg::MODE_ERODE;
            mask_reg   <= '0;
            width_reg  <= bmf_pkg::dim_t'(bmf_pkg::MAX_W);
            height_reg <= bmf_pkg::dim_t'(bmf_pkg::MAX_H);
        end
        else if (wr_en)
        begin
            unique case (idx)
                bmf_pkg::REG_OP_MODE: mode_reg <= bmf_pkg::mode_t'(pwdata[1:0]);
                bmf_pkg::REG_MASK0:   mask_reg[63:0]    <= pwdata;
                bmf_pkg::REG_MASK1:   mask_reg[127:64]  <= pwdata;
                bmf_pkg::REG_MASK2:   mask_reg[191:128] <= pwdata;
                bmf_pkg::REG_MASK3:   mask_reg[224:192] <= pwdata[32:0];
                bmf_pkg::REG_WIDTH:   width_reg  <= pwdata[bmf_pkg::DIM_W-1:0];
                bmf_pkg::REG_HEIGHT:  height_reg <= pwdata[bmf_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bmf_pkg::REG_OP_MODE: prdata = {62'd0, mode_reg};
            bmf_pkg::REG_MASK0:   prdata = mask_reg[63:0];
            bmf_pkg::REG_MASK1:   prdata = mask_reg[127:64];
            bmf_pkg::REG_MASK2:   prdata = mask_reg[191:128];
            bmf_pkg::REG_MASK3:   prdata = {31'd0, mask_reg[224:192]};
            bmf_pkg::REG_WIDTH:   prdata = {53'd0, width_reg};
            bmf_pkg::REG_HEIGHT:  prdata = {53'd0, height_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.mode   = mode_reg;
    assign cfg.mask   = mask_reg;
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

`default_nettype wire

### hw/rtl/bmf_ctrl.sv
// frame control: input counting, frame settings latch and window center tracking
// depends on bmf_pkg
`default_nettype none

module bmf_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic                          cmd,
    input  wire logic [bmf_pkg::PIX_W-1:0]     pixel_in,
    input  bmf_pkg::frame_cfg_t                cfg,
    output bmf_pkg::frame_cfg_t                act,
    output logic                               reserve,
    output logic                               tick_valid,
    output logic                               tick_bit,
    output bmf_pkg::tick_t                     tick_info
);

    logic                     active_reg, active_next;
    logic                     in_done_reg, in_done_next;
    bmf_pkg::dim_t            in_row_reg, in_row_next;
    bmf_pkg::col_t            in_col_reg, in_col_next;
    bmf_pkg::center_t         q1_reg, q1_next;
    bmf_pkg::center_t         qo_reg, qo_next;
    bmf_pkg::frame_cfg_t      act_reg, act_next;
    logic                     tvalid_reg, tvalid_next;
    logic                     tbit_reg, tbit_next;
    bmf_pkg::tick_t           tinfo_reg, tinfo_next;

    logic                     push, accept, in_phase, start, tick, two, emit, last, in_last;
    bmf_pkg::frame_cfg_t      cfg_clamped;
    bmf_pkg::center_t         q1_cur, qo_cur;
    bmf_pkg::dim_t            in_row_cur;
    bmf_pkg::col_t            in_col_cur;
    bmf_pkg::row_t            h_row;

    always_comb
    begin
        cfg_clamped        = cfg;
        cfg_clamped.width  = bmf_pkg::clamp_dim(cfg.width,  bmf_pkg::dim_t'(bmf_pkg::MAX_W));
        cfg_clamped.height = bmf_pkg::clamp_dim(cfg.height, bmf_pkg::dim_t'(bmf_pkg::MAX_H));

        push     = bmf_pkg::cmd_t'(cmd) == bmf_pkg::CMD_PUSH;
        accept   = in_valid && !in_stall;
        in_phase = !active_reg || !in_done_reg;
        start    = !active_reg && push;
        // while pixels are still due, a flush does nothing; afterwards any request ticks
        tick     = accept && (!in_phase || push);

        act_next = start ? cfg_clamped : act_reg;
        two      = (act_next.mode == bmf_pkg::MODE_OPEN) ||
                   (act_next.mode == bmf_pkg::MODE_CLOSE);
        q1_cur   = start ? bmf_pkg::lag_start(act_next.width, 1'b0) : q1_reg;
        qo_cur   = start ? bmf_pkg::lag_start(act_next.width, two) : qo_reg;
        in_row_cur = start ? '0 : in_row_reg;
        in_col_cur = start ? '0 : in_col_reg;

        h_row   = bmf_pkg::row_t'({2'b00, act_next.height});
        emit    = (qo_cur.row >= bmf_pkg::row_t'(0)) && (qo_cur.row < h_row);
        last    = emit && (qo_cur.row == h_row - bmf_pkg::row_t'(1)) &&
                  ({1'b0, qo_cur.col} == act_next.width - bmf_pkg::dim_t'(1));
        in_last = (in_row_cur == act_next.height - bmf_pkg::dim_t'(1)) &&
                  ({1'b0, in_col_cur} == act_next.width - bmf_pkg::dim_t'(1));
        reserve = tick && emit;

        active_next  = active_reg;
        in_done_next = in_done_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        q1_next      = q1_reg;
        qo_next      = qo_reg;
        if (tick)
        begin
            q1_next = bmf_pkg::advance(q1_cur, act_next.width);
            qo_next = bmf_pkg::advance(qo_cur, act_next.width);
            if (in_phase)
            begin
                in_done_next = in_last;
                if (in_col_cur == bmf_pkg::col_t'(act_next.width - bmf_pkg::dim_t'(1)))
                begin
                    in_col_next = '0;
                    in_row_next = in_row_cur + bmf_pkg::dim_t'(1);
                end
                else
                begin
                    in_col_next = in_col_cur + bmf_pkg::col_t'(1);
                    in_row_next = in_row_cur;
                end
            end
            active_next = !last;
            if (last)
                in_done_next = 1'b0;
        end

        tvalid_next           = tick;
        tbit_next             = in_phase && (pixel_in == bmf_pkg::PIX_FG);
        tinfo_next.q1         = q1_cur;
        tinfo_next.qo         = qo_cur;
        tinfo_next.emit       = emit;
        tinfo_next.last       = last;
        tinfo_next.s1_bit     = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            in_done_reg <= 1'b0;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            q1_reg      <= '0;
            qo_reg      <= '0;
            act_reg     <= '0;
            tvalid_reg  <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            in_done_reg <= in_done_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            q1_reg      <= q1_next;
            qo_reg      <= qo_next;
            act_reg     <= act_next;
            tvalid_reg  <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            tbit_reg  <= tbit_next;
            tinfo_reg <= tinfo_next;
        end
    end

    assign act        = act_reg;
    assign tick_valid = tvalid_reg;
    assign tick_bit   = tbit_reg;
    assign tick_info  = tinfo_reg;

endmodule

`default_nettype wire

### hw/rtl/bmf_stage.sv
// one morphology stage: 14-line delay memory, 15x15 window and masked and/or
// depends on bmf_pkg
`default_nettype none

module bmf_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_bit,
    input  bmf_pkg::tick_t         in_info,
    input  bmf_pkg::center_t       center,
    input  bmf_pkg::frame_cfg_t    frame,
    input  wire logic              erode,
    output logic                   out_valid,
    output logic                   out_bit,
    output bmf_pkg::tick_t         out_info
);

    logic [bmf_pkg::TAPS-1:0]  mem [bmf_pkg::MAX_W];
    bmf_pkg::col_t             ptr_reg, ptr_next;
    logic [bmf_pkg::TAPS-1:0]  rd_raw_reg;
    logic                      byp_reg;
    logic [bmf_pkg::TAPS-1:0]  byp_data_reg;
    logic [bmf_pkg::TAPS-1:0]  rd_word, wr_word;
    logic [bmf_pkg::WIN-1:0]   col_bits;

    logic [bmf_pkg::WIN-1:0]   win_reg [bmf_pkg::WIN];
    logic                      wvalid_reg;
    bmf_pkg::center_t          wcenter_reg;
    bmf_pkg::tick_t            winfo_reg;

    logic                      ovalid_reg;
    logic                      obit_reg;
    bmf_pkg::tick_t            oinfo_reg;

    logic [bmf_pkg::WIN-1:0]   row_ok, col_ok;
    logic                      all_v, any_v, res;

    assign rd_word  = byp_reg ? byp_data_reg : rd_raw_reg;
    assign wr_word  = {rd_word[bmf_pkg::TAPS-2:0], in_bit};
    assign col_bits = {rd_word, in_bit};

    always_comb
    begin
        ptr_next = ptr_reg;
        if (in_valid)
        begin
            if (in_info.last || ({1'b0, ptr_reg} == frame.width - bmf_pkg::dim_t'(1)))
                ptr_next = '0;
            else
                ptr_next = ptr_reg + bmf_pkg::col_t'(1);
        end
    end

    // read one slot ahead; bypass when that slot is written on the same edge
    always_ff @(posedge clk)
    begin
        if (in_valid)
            mem[ptr_reg] <= wr_word;
        rd_raw_reg   <= mem[ptr_next];
        byp_data_reg <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            byp_reg    <= 1'b0;
            wvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            byp_reg    <= in_valid && (ptr_next == ptr_reg);
            wvalid_reg <= in_valid;
            ovalid_reg <= wvalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            for (int i = 0; i < bmf_pkg::WIN; i++)
                win_reg[i] <= {win_reg[i][bmf_pkg::WIN-2:0], col_bits[i]};
            wcenter_reg <= center;
            winfo_reg   <= in_info;
        end
        if (wvalid_reg)
        begin
            obit_reg  <= res;
            oinfo_reg <= winfo_reg;
        end
    end

    // tap (i, j) sits at row offset 7-i and column offset 7-j from the center
    always_comb
    begin
        logic signed [bmf_pkg::ROW_W-1:0] rr;
        logic signed [bmf_pkg::COL_W-1:0] cc;
        logic                             hit, ok;
        int                               k;
        for (int i = 0; i < bmf_pkg::WIN; i++)
        begin
            rr = wcenter_reg.row + bmf_pkg::ROW_W'(bmf_pkg::HALF - i);
            row_ok[i] = (rr >= 0) && (rr < bmf_pkg::row_t'({2'b00, frame.height}));
        end
        for (int j = 0; j < bmf_pkg::WIN; j++)
        begin
            cc = signed'({2'b00, wcenter_reg.col}) + bmf_pkg::COL_W'(bmf_pkg::HALF - j);
            col_ok[j] = (cc >= 0) && (cc < signed'({1'b0, frame.width}));
        end
        all_v = 1'b1;
        any_v = 1'b0;
        for (int i = 0; i < bmf_pkg::WIN; i++)
        begin
            for (int j = 0; j < bmf_pkg::WIN; j++)
            begin
                k     = (bmf_pkg::WIN - 1 - i) * bmf_pkg::WIN + (bmf_pkg::WIN - 1 - j);
                hit   = frame.mask[k];
                ok    = row_ok[i] && col_ok[j] && win_reg[i][j];
                all_v = all_v && (!hit || ok);
                any_v = any_v || (hit && ok);
            end
        end
        res = erode ? all_v : any_v;
    end

    assign out_valid = ovalid_reg;
    assign out_bit   = obit_reg;
    assign out_info  = oinfo_reg;

endmodule

`default_nettype wire

### hw/rtl/bmf_out_fifo.sv
// result queue with slot reservation so accepted requests never overflow it
// depends on bmf_pkg
`default_nettype none

module bmf_out_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          reserve,
    input  wire logic                          push,
    input  wire logic                          push_bit,
    input  wire logic                          push_last,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [bmf_pkg::PIX_W-1:0]          pixel_out,
    output logic                               frame_last,
    output logic                               full
);

    logic [1:0]                       q_reg [bmf_pkg::FIFO_DEPTH];
    logic [bmf_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [bmf_pkg::FIFO_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [bmf_pkg::FIFO_CNT_W-1:0]   credit_reg, credit_next;
    logic                             pop;

    assign out_valid  = cnt_reg != '0;
    assign pop        = out_valid && !out_stall;
    assign pixel_out  = q_reg[rd_ptr_reg][1] ? bmf_pkg::PIX_FG : bmf_pkg::PIX_BG;
    assign frame_last = q_reg[rd_ptr_reg][0];
    assign full       = credit_reg == bmf_pkg::FIFO_CNT_W'(bmf_pkg::FIFO_DEPTH);

    always_comb
    begin
        cnt_next    = cnt_reg + bmf_pkg::FIFO_CNT_W'(push) - bmf_pkg::FIFO_CNT_W'(pop);
        credit_next = credit_reg + bmf_pkg::FIFO_CNT_W'(reserve) -
                      bmf_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            credit_reg <= credit_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + bmf_pkg::FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + bmf_pkg::FIFO_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= {push_bit, push_last};
    end

endmodule

`default_nettype wire

### hw/rtl/binary_morphology_filter_top.sv
// binary morphology filter (erosion, dilation, opening, closing) over a pixel stream
// top level; depends on bmf_pkg, bmf_cfg_regs, bmf_ctrl, bmf_stage, bmf_out_fifo
//
// usage:
//   input channel (in_valid/in_stall, cmd, pixel_in): raster-order pixels, foreground
//   is exactly 255; after the last pixel send flush requests until frame_last appears.
//   output channel (out_valid/out_stall, pixel_out, frame_last): 0 or 255 in raster order.
//   apb port: op_mode, four mask words, frame width and height, 8-byte spacing.
//   frame settings are latched by the first pixel of each frame.
// timing:
//   one request per clock sustained while in_stall is low. a pixel's result leaves
//   7*width+7 requests later (twice that for opening and closing), after the pipeline
//   registers: control register, window register and result register of each of the
//   two window stages, then the output queue.
// stall:
//   an 8-entry output queue takes results while out_stall is high; requests that
//   will produce a result reserve a slot on entry, and in_stall rises only when all
//   slots are taken.
// reset:
//   all control state clears, registers return to erosion, empty mask, 1024x1024;
//   line memories hold stale data that the frame edge masking hides.
`default_nettype none

module binary_morphology_filter_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic [bmf_pkg::PIX_W-1:0]     pixel_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bmf_pkg::PIX_W-1:0]          pixel_out,
    output logic                               frame_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bmf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bmf_pkg::DATA_W-1:0]    pwdata,
    output logic      [bmf_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    bmf_pkg::frame_cfg_t   cfg, act;
    logic                  reserve, full;
    logic                  t_valid, t_bit;
    bmf_pkg::tick_t        t_info;
    logic                  s1_valid, s1_bit;
    bmf_pkg::tick_t        s1_info, s2_in_info;
    logic                  s2_valid, s2_bit;
    bmf_pkg::tick_t        s2_info;
    logic                  two, erode1, erode2, result;

    assign in_stall = full;

    bmf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (full),
        .cmd        (cmd),
        .pixel_in   (pixel_in),
        .cfg        (cfg),
        .act        (act),
        .reserve    (reserve),
        .tick_valid (t_valid),
        .tick_bit   (t_bit),
        .tick_info  (t_info)
    );

    assign two    = (act.mode == bmf_pkg::MODE_OPEN) || (act.mode == bmf_pkg::MODE_CLOSE);
    assign erode1 = (act.mode == bmf_pkg::MODE_ERODE) || (act.mode == bmf_pkg::MODE_OPEN);
    assign erode2 = act.mode == bmf_pkg::MODE_CLOSE;

    bmf_stage u_stage1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_bit    (t_bit),
        .in_info   (t_info),
        .center    (t_info.q1),
        .frame     (act),
        .erode     (erode1),
        .out_valid (s1_valid),
        .out_bit   (s1_bit),
        .out_info  (s1_info)
    );

    // the first-stage bit rides along for the single-stage modes
    always_comb
    begin
        s2_in_info        = s1_info;
        s2_in_info.s1_bit = s1_bit;
    end

    bmf_stage u_stage2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_bit    (s1_bit),
        .in_info   (s2_in_info),
        .center    (s1_info.qo),
        .frame     (act),
        .erode     (erode2),
        .out_valid (s2_valid),
        .out_bit   (s2_bit),
        .out_info  (s2_info)
    );

    assign result = two ? s2_bit : s2_info.s1_bit;

    bmf_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .reserve    (reserve),
        .push       (s2_valid && s2_info.emit),
        .push_bit   (result),
        .push_last  (s2_info.last),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .pixel_out  (pixel_out),
        .frame_last (frame_last),
        .full       (full)
    );

endmodule

`default_nettype wire

### hw/rtl/bmf_checker.sv
// port-level checker for the morphology filter, bound to the top level
// depends on bmf_pkg and binary_morphology_filter_top_defines.svh
`default_nettype none
`include "binary_morphology_filter_top_defines.svh"

module bmf_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [bmf_pkg::PIX_W-1:0]     pixel_out,
    input  wire logic                          frame_last,
    input  wire logic                          psel,
    input  wire logic                          pwrite,
    input  wire logic [bmf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bmf_pkg::DATA_W-1:0]    prdata
);

    // results are binary
    `BMF_ASSERT_SAME(a_pix_binary, out_valid, (pixel_out == bmf_pkg::PIX_FG) || (pixel_out == bmf_pkg::PIX_BG), "pixel_out not 0 or 255")

    // a stalled result stays put
    `BMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_out) && $stable(frame_last), "stalled result changed")

    // the mode register reads back only two bits
    `BMF_ASSERT_SAME(a_mode_read, psel && !pwrite && (paddr[bmf_pkg::ADDR_W-1:3] == bmf_pkg::REG_OP_MODE), prdata[bmf_pkg::DATA_W-1:2] == '0, "op_mode readback too wide")

endmodule

bind binary_morphology_filter_top bmf_checker u_bmf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .psel       (psel),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .prdata     (prdata)
);

`default_nettype wire

### tb/sv/binary_morphology_filter_top_test.sv
// self-checking testbench of binary_morphology_filter_top: frames of pixels with random
// masks, modes and sizes; results checked against a bit-exact predictor in this module
// depends on bmf_pkg and the rtl of binary_morphology_filter_top
`default_nettype none

module binary_morphology_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bmf_pkg::*;

    localparam int STORE       = 2 * HALF * MAX_W + 2 * HALF + 1;
    localparam int RAND_ITEMS  = 1850;
    localparam int STALL_LIMIT = 3000;

    typedef enum int { MK_EMPTY, MK_FULL, MK_CENTER, MK_CROSS, MK_SPARSE, MK_RAND } mask_kind_t;
    typedef enum int { PP_FG, PP_BG, PP_GRAY, PP_MIX } pix_kind_t;

    typedef struct {
        mode_t      mode;
        mask_kind_t mk;
        int         w_raw;
        int         h_raw;
        pix_kind_t  pk;
        bit         junk_hi;
        bit         known;
        logic [7:0] known_pix;
    } frame_row_t;

    typedef struct {
        cmd_t       c;
        logic [7:0] p;
    } request_t;

    typedef struct {
        logic [7:0] pix;
        bit         last;
    } pix_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid;
    logic                in_stall;
    logic                cmd;
    logic [PIX_W-1:0]    pixel_in;
    logic                out_valid;
    logic                out_stall;
    logic [PIX_W-1:0]    pixel_out;
    logic                frame_last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    binary_morphology_filter_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .frame_last (frame_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    // register copies and the settings latched at the start of a frame
    logic [1:0]           reg_mode;
    logic [MASK_BITS-1:0] reg_mask;
    logic [10:0]          reg_w, reg_h;
    mode_t                frm_mode;
    logic [MASK_BITS-1:0] frm_mask;
    int                   frm_w, frm_h, frm_n;
    bit                   fg_ring [STORE];
    bit                   stage1_ring [STORE];
    int                   ticks_in_frame;

    request_t    request_q[$];
    pix_result_t pixel_exp_q[$];
    request_t    drive_req;
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          frames_run = 0;
    int          mode_frames [4];
    int          cycle_cnt = 0;
    int          quiet_cnt = 0;
    bit          quiet;
    bit          row_known = 1'b0;
    logic [7:0]  row_pix = '0;

    function automatic int clamp_dim_int(input logic [10:0] v, input int lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return int'(v);
    endfunction

    function automatic bit window_hit(input bit second, input int q, input bit erode);
        int  r, c, rr, cc, k;
        bit  any_fg, all_fg, v;
        r = q / frm_w;
        c = q % frm_w;
        any_fg = 1'b0;
        all_fg = 1'b1;
        for (int dr = -HALF; dr <= HALF; dr++) begin
            for (int dc = -HALF; dc <= HALF; dc++) begin
                k = (dr + HALF) * WIN + (dc + HALF);
                if (frm_mask[k]) begin
                    rr = r + dr;
                    cc = c + dc;
                    v = 1'b0;
                    if (rr >= 0 && rr < frm_h && cc >= 0 && cc < frm_w)
                        v = second ? stage1_ring[(rr * frm_w + cc) % STORE]
                                   : fg_ring[(rr * frm_w + cc) % STORE];
                    any_fg = any_fg | v;
                    all_fg = all_fg & v;
                end
            end
        end
        return erode ? all_fg : any_fg;
    endfunction

    // advances the filter state by one accepted request; returns 1 with a result
    function automatic bit filter_tick(input cmd_t c, input logic [7:0] p,
                                       output pix_result_t res);
        int t, lag, span, q1, o;
        bit two, erode1, v;
        if (ticks_in_frame < frm_n || ticks_in_frame == 0) begin
            if (c == CMD_FLUSH)
                return 1'b0;
            if (ticks_in_frame == 0) begin
                frm_mode = mode_t'(reg_mode);
                frm_mask = reg_mask;
                frm_w = clamp_dim_int(reg_w, MAX_W);
                frm_h = clamp_dim_int(reg_h, MAX_H);
                frm_n = frm_w * frm_h;
            end
            fg_ring[ticks_in_frame % STORE] = (p == PIX_FG);
        end
        ticks_in_frame++;
        t = ticks_in_frame;
        span = HALF * frm_w + HALF;
        two = (frm_mode == MODE_OPEN || frm_mode == MODE_CLOSE);
        erode1 = (frm_mode == MODE_ERODE || frm_mode == MODE_OPEN);
        lag = two ? 2 * span : span;
        if (two) begin
            q1 = t - 1 - span;
            if (q1 >= 0 && q1 < frm_n)
                stage1_ring[q1 % STORE] = window_hit(1'b0, q1, erode1);
        end
        o = t - 1 - lag;
        if (o < 0 || o >= frm_n)
            return 1'b0;
        v = two ? window_hit(1'b1, o, !erode1) : window_hit(1'b0, o, erode1);
        res.pix = v ? PIX_FG : PIX_BG;
        res.last = (o == frm_n - 1);
        if (res.last)
            ticks_in_frame = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // quiet stretch: no idling on either side
    always_comb quiet = (cycle_cnt >= 3000 && cycle_cnt < 6000);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            cmd <= CMD_PUSH;
            pixel_in <= '0;
            out_stall <= 1'b0;
        end
        else begin
            out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 36);
            if (!(in_valid && in_stall)) begin
                if (request_q.size() > 0 && (quiet || $urandom_range(99) >= 36)) begin
                    drive_req = request_q.pop_front();
                    in_valid <= 1'b1;
                    cmd <= drive_req.c;
                    pixel_in <= drive_req.p;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // acceptance of requests and results, and the stall watchdog
    always @(posedge clk)
    begin
        pix_result_t res;
        pix_result_t want;
        bit          got;
        if (rst_n) begin
            cycle_cnt <= cycle_cnt + 1;
            quiet_cnt <= quiet_cnt + 1;
            if (in_valid && !in_stall) begin
                quiet_cnt <= 0;
                items_sent++;
                got = filter_tick(cmd_t'(cmd), pixel_in, res);
                if (got) begin
                    if (row_known)
                        res.pix = row_pix;
                    pixel_exp_q.push_back(res);
                end
            end
            if (out_valid && !out_stall) begin
                quiet_cnt <= 0;
                results_seen++;
                if (pixel_exp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result pixel_out=%0d", pixel_out));
                end
                else begin
                    want = pixel_exp_q.pop_front();
                    if (pixel_out !== want.pix)
                        report_mismatch($sformatf("pixel_out=%0d expected %0d",
                                                  pixel_out, want.pix));
                    if (frame_last !== want.last)
                        report_mismatch($sformatf("frame_last=%0b expected %0b",
                                                  frame_last, want.last));
                end
            end
            if (quiet_cnt >= STALL_LIMIT) begin
                $display("binary_morphology_filter_top_test failed");
                $finish;
            end
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 3'b000});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (!(request_q.size() == 0 && !in_valid && pixel_exp_q.size() == 0))
            @(posedge clk);
        // flush requests leave no result but may still be in the pipeline
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [MASK_BITS-1:0] build_mask(input mask_kind_t mk);
        logic [MASK_BITS-1:0] m;
        int k;
        m = '0;
        case (mk)
            MK_FULL:   m = '1;
            MK_CENTER: m[HALF * WIN + HALF] = 1'b1;
            MK_CROSS:
                for (int i = 0; i < WIN; i++) begin
                    m[HALF * WIN + i] = 1'b1;
                    m[i * WIN + HALF] = 1'b1;
                end
            MK_SPARSE:
                for (int i = 0; i < 5; i++) begin
                    k = $urandom_range(HALF + 2, HALF - 2) * WIN + $urandom_range(HALF + 2, HALF - 2);
                    m[k] = 1'b1;
                end
            MK_RAND:
                for (int i = 0; i < MASK_BITS; i++)
                    m[i] = ($urandom_range(9) == 0);
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] pick_pixel(input pix_kind_t pk);
        case (pk)
            PP_FG:   return PIX_FG;
            PP_BG:   return PIX_BG;
            PP_GRAY: return 8'($urandom_range(254));
            default: begin
                if ($urandom_range(99) < 60) return PIX_FG;
                if ($urandom_range(99) < 75) return PIX_BG;
                return 8'($urandom);
            end
        endcase
    endfunction

    // writes the settings, queues one frame with its drain and some noise, waits for it
    task automatic run_frame(input frame_row_t row);
        logic [MASK_BITS-1:0] m;
        logic [63:0]          m3;
        int                   w, h, lag;
        request_t             rq;
        m = build_mask(row.mk);
        m3 = 64'(m[MASK_BITS-1:192]);
        if (row.junk_hi)
            m3 = m3 | {31'h7fffffff, 33'h0};
        apb_write(REG_OP_MODE, 64'(row.mode));
        apb_write(REG_MASK0, m[63:0]);
        apb_write(REG_MASK1, m[127:64]);
        apb_write(REG_MASK2, m[191:128]);
        apb_write(REG_MASK3, m3);
        apb_write(REG_WIDTH, 64'(row.w_raw));
        apb_write(REG_HEIGHT, 64'(row.h_raw));
        reg_mode = row.mode;
        reg_mask = m;
        reg_w = 11'(row.w_raw);
        reg_h = 11'(row.h_raw);
        row_known = row.known;
        row_pix = row.known_pix;
        w = clamp_dim_int(reg_w, MAX_W);
        h = clamp_dim_int(reg_h, MAX_H);
        lag = HALF * w + HALF;
        if (row.mode == MODE_OPEN || row.mode == MODE_CLOSE)
            lag = 2 * lag;
        // early flushes with no frame in progress are ignored
        for (int i = $urandom_range(2); i > 0; i--) begin
            rq.c = CMD_FLUSH;
            rq.p = 8'($urandom);
            request_q.push_back(rq);
        end
        for (int i = 0; i < w * h; i++) begin
            rq.c = CMD_PUSH;
            rq.p = pick_pixel(row.pk);
            request_q.push_back(rq);
        end
        // drain; a surplus push counts as a flush
        for (int i = 0; i < lag; i++) begin
            rq.c = ($urandom_range(99) < 20) ? CMD_PUSH : CMD_FLUSH;
            rq.p = 8'($urandom);
            request_q.push_back(rq);
        end
        for (int i = $urandom_range(1); i > 0; i--) begin
            rq.c = CMD_FLUSH;
            request_q.push_back(rq);
        end
        wait_drained();
        row_known = 1'b0;
        frames_run++;
        mode_frames[row.mode]++;
    endtask

    frame_row_t directed_rows [] = '{
        '{MODE_ERODE,  MK_EMPTY,  3,    3,    PP_BG,   1'b0, 1'b1, 8'd255},
        '{MODE_DILATE, MK_EMPTY,  4,    2,    PP_FG,   1'b0, 1'b1, 8'd0},
        '{MODE_ERODE,  MK_FULL,   0,    1,    PP_FG,   1'b0, 1'b1, 8'd0},
        '{MODE_DILATE, MK_FULL,   6,    3,    PP_GRAY, 1'b0, 1'b1, 8'd0},
        '{MODE_DILATE, MK_CROSS,  2047, 1,    PP_MIX,  1'b0, 1'b0, 8'd0},
        '{MODE_CLOSE,  MK_CENTER, 1,    2047, PP_MIX,  1'b0, 1'b0, 8'd0},
        '{MODE_OPEN,   MK_FULL,   15,   15,   PP_FG,   1'b1, 1'b0, 8'd0},
        '{MODE_CLOSE,  MK_CROSS,  7,    5,    PP_MIX,  1'b0, 1'b0, 8'd0},
        '{MODE_ERODE,  MK_SPARSE, 9,    4,    PP_MIX,  1'b1, 1'b0, 8'd0},
        '{MODE_OPEN,   MK_RAND,   1,    1,    PP_FG,   1'b0, 1'b0, 8'd0}
    };

    initial
    begin
        frame_row_t row;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cmd = CMD_PUSH;
        pixel_in = '0;
        reg_mode = MODE_ERODE;
        reg_mask = '0;
        reg_w = 11'd1024;
        reg_h = 11'd1024;
        frm_mode = MODE_ERODE;
        frm_mask = '0;
        frm_w = 1;
        frm_h = 1;
        frm_n = 1;
        ticks_in_frame = 0;
        foreach (mode_frames[i])
            mode_frames[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            run_frame(directed_rows[i]);

        while (items_sent < RAND_ITEMS + 9000 || results_seen < 1200) begin
            row.mode = mode_t'($urandom_range(3));
            row.mk = mask_kind_t'($urandom_range(5));
            row.w_raw = ($urandom_range(19) == 0) ? $urandom_range(64) : $urandom_range(16, 1);
            row.h_raw = $urandom_range(8, 1);
            row.pk = ($urandom_range(9) == 0) ? pix_kind_t'($urandom_range(2)) : PP_MIX;
            row.junk_hi = $urandom_range(1);
            row.known = 1'b0;
            row.known_pix = '0;
            run_frame(row);
        end

        wait_drained();
        $display("%0d frames (erode %0d, dilate %0d, open %0d, close %0d)", frames_run,
                 mode_frames[0], mode_frames[1], mode_frames[2], mode_frames[3]);
        $display("%0d requests accepted, %0d pixels checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        if (mismatches == 0 && pixel_exp_q.size() == 0)
            $display("binary_morphology_filter_top_test passed");
        else
            $display("binary_morphology_filter_top_test failed");
        $finish;
    end

endmodule

`default_nettype wire
